/* design/afps_pkg.sv */
// Package for the A/V frame pacing block: types, constants and saturating time arithmetic.
`default_nettype none

package afps_pkg;

   // Time values are signed microseconds at this width
   localparam int TIME_BITS = 48;
   localparam int DUR_BITS = 24;
   localparam int DELAY_BITS = TIME_BITS - 1;
   localparam int SLEEP_BITS = 20;
   localparam int DROP_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int THR_BITS = 20;
   localparam int OFFSET_BITS = 24;

   typedef logic signed [TIME_BITS-1:0] time_type;

   localparam time_type TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
   localparam time_type TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

   // Frame duration limits and the lead point above which delay is stretched, not doubled
   localparam time_type DUR_MIN = time_type'(1000);
   localparam time_type DUR_MAX = time_type'(1000000);
   localparam time_type DUP_THRESHOLD = time_type'(100000);

   // Register reset values
   localparam logic [THR_BITS-1:0] SYNC_THR_MIN_RST = THR_BITS'(40000);
   localparam logic [THR_BITS-1:0] SYNC_THR_MAX_RST = THR_BITS'(100000);
   localparam logic [OFFSET_BITS-1:0] MAX_AV_OFFSET_RST = OFFSET_BITS'(500000);
   localparam logic [SLEEP_BITS-1:0] MIN_SLEEP_RST = SLEEP_BITS'(1000);
   localparam logic [SLEEP_BITS-1:0] MAX_SLEEP_RST = SLEEP_BITS'(200000);
   localparam logic [OFFSET_BITS-1:0] RESYNC_LAG_RST = OFFSET_BITS'(100000);
   localparam logic [DROP_BITS-1:0] DROP_LIMIT_RST = DROP_BITS'(1);

   typedef enum logic [1:0] {
      CMD_PREPARE  = 2'd0,
      CMD_FINALIZE = 2'd1,
      CMD_RESTART  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SYNC_THR_MIN  = 3'd0,
      CSR_SYNC_THR_MAX  = 3'd1,
      CSR_MAX_AV_OFFSET = 3'd2,
      CSR_MIN_SLEEP     = 3'd3,
      CSR_MAX_SLEEP     = 3'd4,
      CSR_RESYNC_LAG    = 3'd5,
      CSR_DROP_LIMIT    = 3'd6
   } csr_index_type;

   // Input transaction payload
   typedef struct packed {
      logic [1:0]           cmd;
      time_type             frame_pts;
      logic [DUR_BITS-1:0]  nominal_duration;
      time_type             audio_clock;
      time_type             wall_now;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic                  is_final;
      logic [DUR_BITS-1:0]   frame_duration;
      time_type              av_diff;
      logic [DELAY_BITS-1:0] delay;
      logic [SLEEP_BITS-1:0] sleep_time;
      logic                  timeline_reset;
      time_type              frame_timer;
      logic [DROP_BITS-1:0]  drop_count;
      logic                  render;
   } rsp_type;

   // a + b, saturated to the signed time range
   function automatic time_type sat_add(time_type a, time_type b);
      logic [TIME_BITS:0] s;
      s = {a[TIME_BITS-1], a} + {b[TIME_BITS-1], b};
      if (s[TIME_BITS] != s[TIME_BITS-1]) begin
         return s[TIME_BITS] ? TIME_MIN : TIME_MAX;
      end
      return time_type'(s[TIME_BITS-1:0]);
   endfunction

   // a - b, saturated to the signed time range
   function automatic time_type sat_sub(time_type a, time_type b);
      logic [TIME_BITS:0] s;
      s = {a[TIME_BITS-1], a} - {b[TIME_BITS-1], b};
      if (s[TIME_BITS] != s[TIME_BITS-1]) begin
         return s[TIME_BITS] ? TIME_MIN : TIME_MAX;
      end
      return time_type'(s[TIME_BITS-1:0]);
   endfunction

   // Low bound checked first, so a low bound above the high one wins only below it
   function automatic time_type clamp(time_type v, time_type lo, time_type hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* design/afps_stream_if.sv */
// Valid/ready channel interface carrying one command transaction.
`default_nettype none

interface afps_stream_if
   import afps_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   time_type             frame_pts;
   logic [DUR_BITS-1:0]  nominal_duration;
   time_type             audio_clock;
   time_type             wall_now;

   modport source (output valid, output cmd, output frame_pts, output nominal_duration,
                   output audio_clock, output wall_now, input ready);
   modport sink (input valid, input cmd, input frame_pts, input nominal_duration,
                 input audio_clock, input wall_now, output ready);
endinterface

`default_nettype wire

/* design/afps_result_if.sv */
// Valid/ready channel interface carrying one pacing result transaction.
`default_nettype none

interface afps_result_if
   import afps_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic                  is_final;
   logic [DUR_BITS-1:0]   frame_duration;
   time_type              av_diff;
   logic [DELAY_BITS-1:0] delay;
   logic [SLEEP_BITS-1:0] sleep_time;
   logic                  timeline_reset;
   time_type              frame_timer;
   logic [DROP_BITS-1:0]  drop_count;
   logic                  render;

   modport source (output valid, output is_final, output frame_duration, output av_diff,
                   output delay, output sleep_time, output timeline_reset,
                   output frame_timer, output drop_count, output render, input ready);
   modport sink (input valid, input is_final, input frame_duration, input av_diff,
                 input delay, input sleep_time, input timeline_reset,
                 input frame_timer, input drop_count, input render, output ready);
endinterface

`default_nettype wire

/* design/av_frame_pacing_sync_top.sv */
// Top level of the A/V frame pacing block: input register, pacing logic and result register.
//
// Each command transaction is captured in an input register, evaluated there by one pass
// of combinational pacing logic, and written into the result register together with the
// timer, drop and held-frame state. The block takes one transaction every clock cycle
// while rsp is ready; a prepare or finalize result is valid on rsp once it has moved
// from the input register into the result register. A restart clears the pacing state
// and an unused command code leaves it alone; neither produces a result.
// While a result waits on rsp, one more transaction can be taken into the input register;
// a prepare or finalize held there then stalls req until rsp takes the waiting result,
// while restarts and unused codes keep moving. Configuration writes on the csr port take
// effect at once and should be made only while the block is idle.
`default_nettype none

module av_frame_pacing_sync_top
   import afps_pkg::*;
   (
   input  wire logic                      clock,
   input  wire logic                      reset,
   afps_stream_if.sink                    req,
   afps_result_if.source                  rsp,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
   );

   // Configuration registers
   logic [THR_BITS-1:0]    sync_thr_min_ff;
   logic [THR_BITS-1:0]    sync_thr_max_ff;
   logic [OFFSET_BITS-1:0] max_av_offset_ff;
   logic [SLEEP_BITS-1:0]  min_sleep_ff;
   logic [SLEEP_BITS-1:0]  max_sleep_ff;
   logic [OFFSET_BITS-1:0] resync_lag_ff;
   logic [DROP_BITS-1:0]   drop_limit_ff;

   // Pacing state
   time_type               timer_ff;
   time_type               last_pts_ff;
   logic                   timer_valid_ff;
   logic [DROP_BITS-1:0]   drops_ff;
   logic [DELAY_BITS-1:0]  held_delay_ff;
   logic [DUR_BITS-1:0]    held_dur_ff;
   time_type               held_diff_ff;
   logic [SLEEP_BITS-1:0]  held_sleep_ff;

   // Input and result registers
   req_type                in_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   logic                   req_accept;
   logic                   has_result;
   logic                   advance;

   // Pacing datapath
   logic                   has_audio;
   time_type               pts_step;
   time_type               dur_clamped;
   logic [DUR_BITS-1:0]    prep_dur;
   time_type               dur_t;
   time_type               prep_diff;
   time_type               offset_lim;
   time_type               av_offset;
   time_type               start_timer;
   time_type               prep_timer;
   time_type               thr;
   time_type               lag_sum;
   time_type               lead_sum;
   time_type               prep_delay;
   time_type               remaining;
   logic [SLEEP_BITS-1:0]  prep_sleep;
   time_type               adv_timer;
   time_type               lag_gap;
   time_type               fin_timer;
   time_type               frame_end;
   logic                   fin_drop;

   // Configuration writes; indexes beyond the register list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_thr_min_ff  <= SYNC_THR_MIN_RST;
         sync_thr_max_ff  <= SYNC_THR_MAX_RST;
         max_av_offset_ff <= MAX_AV_OFFSET_RST;
         min_sleep_ff     <= MIN_SLEEP_RST;
         max_sleep_ff     <= MAX_SLEEP_RST;
         resync_lag_ff    <= RESYNC_LAG_RST;
         drop_limit_ff    <= DROP_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_THR_MIN:  sync_thr_min_ff  <= csr_wdata[THR_BITS-1:0];
            CSR_SYNC_THR_MAX:  sync_thr_max_ff  <= csr_wdata[THR_BITS-1:0];
            CSR_MAX_AV_OFFSET: max_av_offset_ff <= csr_wdata[OFFSET_BITS-1:0];
            CSR_MIN_SLEEP:     min_sleep_ff     <= csr_wdata[SLEEP_BITS-1:0];
            CSR_MAX_SLEEP:     max_sleep_ff     <= csr_wdata[SLEEP_BITS-1:0];
            CSR_RESYNC_LAG:    resync_lag_ff    <= csr_wdata[OFFSET_BITS-1:0];
            CSR_DROP_LIMIT:    drop_limit_ff    <= csr_wdata[DROP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Flow control: the held transaction moves on when its result has somewhere to go
   assign has_result = (in_ff.cmd == CMD_PREPARE) || (in_ff.cmd == CMD_FINALIZE);
   assign advance = in_valid_ff && (!has_result || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_accept = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.cmd              <= req.cmd;
         in_ff.frame_pts        <= req.frame_pts;
         in_ff.nominal_duration <= req.nominal_duration;
         in_ff.audio_clock      <= req.audio_clock;
         in_ff.wall_now         <= req.wall_now;
      end
   end

   // Prepare: frame duration, A/V difference and timer start
   assign has_audio = !in_ff.audio_clock[TIME_BITS-1];
   assign pts_step = sat_sub(in_ff.frame_pts, last_pts_ff);
   assign dur_clamped = clamp(pts_step, DUR_MIN, DUR_MAX);
   assign prep_dur = (!last_pts_ff[TIME_BITS-1] && (in_ff.frame_pts > last_pts_ff))
                     ? dur_clamped[DUR_BITS-1:0] : in_ff.nominal_duration;
   assign dur_t = time_type'(prep_dur);
   assign prep_diff = has_audio ? sat_sub(in_ff.frame_pts, in_ff.audio_clock) : '0;

   assign offset_lim = time_type'(max_av_offset_ff);
   assign av_offset = clamp(sat_sub(in_ff.audio_clock, in_ff.frame_pts), -offset_lim,
                            offset_lim);
   assign start_timer = has_audio ? sat_sub(in_ff.wall_now, av_offset) : in_ff.wall_now;
   assign prep_timer = timer_valid_ff ? timer_ff : start_timer;

   // Prepare: delay shortened when video lags, stretched or doubled when it leads
   assign thr = clamp(dur_t, time_type'(sync_thr_min_ff), time_type'(sync_thr_max_ff));
   assign lag_sum = sat_add(dur_t, prep_diff);
   assign lead_sum = (dur_t > DUP_THRESHOLD) ? lag_sum : (dur_t <<< 1);

   always_comb begin
      prep_delay = dur_t;
      if (has_audio) begin
         priority if (prep_diff <= -thr) begin
            prep_delay = lag_sum[TIME_BITS-1] ? '0 : lag_sum;
         end else if (prep_diff >= thr) begin
            prep_delay = lead_sum;
         end else begin
            prep_delay = dur_t;
         end
      end
   end

   // Prepare: sleep suggestion, capped
   assign remaining = sat_sub(sat_add(prep_timer, prep_delay), in_ff.wall_now);

   always_comb begin
      prep_sleep = '0;
      if (remaining > time_type'(min_sleep_ff)) begin
         prep_sleep = (remaining > time_type'(max_sleep_ff)) ? max_sleep_ff
                                                             : remaining[SLEEP_BITS-1:0];
      end
   end

   // Finalize: advance the timer, snap it forward on large lag, decide on a drop
   assign adv_timer = sat_add(timer_ff, time_type'(held_delay_ff));
   assign lag_gap = sat_sub(in_ff.wall_now, adv_timer);
   assign fin_timer = (lag_gap > time_type'(resync_lag_ff)) ? in_ff.wall_now : adv_timer;
   assign frame_end = sat_add(fin_timer, time_type'(held_dur_ff));
   assign fin_drop = has_audio && (in_ff.wall_now > frame_end) && (drops_ff < drop_limit_ff);

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff       <= '0;
         last_pts_ff    <= '1;
         timer_valid_ff <= 1'b0;
         drops_ff       <= '0;
         held_delay_ff  <= '0;
         held_dur_ff    <= '0;
         held_diff_ff   <= '0;
         held_sleep_ff  <= '0;
      end else if (advance) begin
         unique case (in_ff.cmd)
            CMD_PREPARE: begin
               timer_ff       <= prep_timer;
               last_pts_ff    <= in_ff.frame_pts;
               timer_valid_ff <= 1'b1;
               held_delay_ff  <= prep_delay[DELAY_BITS-1:0];
               held_dur_ff    <= prep_dur;
               held_diff_ff   <= prep_diff;
               held_sleep_ff  <= prep_sleep;
            end
            CMD_FINALIZE: begin
               timer_ff <= fin_timer;
               drops_ff <= fin_drop ? drops_ff + DROP_BITS'(1) : '0;
            end
            CMD_RESTART: begin
               timer_ff       <= '0;
               last_pts_ff    <= '1;
               timer_valid_ff <= 1'b0;
               drops_ff       <= '0;
               held_delay_ff  <= '0;
               held_dur_ff    <= '0;
               held_diff_ff   <= '0;
               held_sleep_ff  <= '0;
            end
            default: ;
         endcase
      end
   end

   // Result payload
   always_comb begin
      rsp_in.is_final       = (in_ff.cmd == CMD_FINALIZE);
      rsp_in.frame_duration = prep_dur;
      rsp_in.av_diff        = prep_diff;
      rsp_in.delay          = prep_delay[DELAY_BITS-1:0];
      rsp_in.sleep_time     = prep_sleep;
      rsp_in.timeline_reset = !timer_valid_ff;
      rsp_in.frame_timer    = prep_timer;
      rsp_in.drop_count     = drops_ff;
      rsp_in.render         = 1'b0;
      if (in_ff.cmd == CMD_FINALIZE) begin
         rsp_in.frame_duration = held_dur_ff;
         rsp_in.av_diff        = held_diff_ff;
         rsp_in.delay          = held_delay_ff;
         rsp_in.sleep_time     = held_sleep_ff;
         rsp_in.timeline_reset = 1'b0;
         rsp_in.frame_timer    = fin_timer;
         rsp_in.drop_count     = fin_drop ? drops_ff + DROP_BITS'(1) : '0;
         rsp_in.render         = !fin_drop;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.is_final       = rsp_ff.is_final;
   assign rsp.frame_duration = rsp_ff.frame_duration;
   assign rsp.av_diff        = rsp_ff.av_diff;
   assign rsp.delay          = rsp_ff.delay;
   assign rsp.sleep_time     = rsp_ff.sleep_time;
   assign rsp.timeline_reset = rsp_ff.timeline_reset;
   assign rsp.frame_timer    = rsp_ff.frame_timer;
   assign rsp.drop_count     = rsp_ff.drop_count;
   assign rsp.render         = rsp_ff.render;

   // A new result only appears when a transaction has just moved on
   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(advance))
      else $error("result appeared without an advancing transaction");

   // A prepare on a stopped timer starts it and flags the timeline reset
   a_timer_start: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.cmd == CMD_PREPARE) && !timer_valid_ff)
      |=> (timer_valid_ff && rsp_valid_ff && rsp_ff.timeline_reset))
      else $error("prepare did not start the frame timer");

   // Restart leaves the state as after reset
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.cmd == CMD_RESTART))
      |=> (!timer_valid_ff && (drops_ff == '0) && last_pts_ff[TIME_BITS-1]))
      else $error("restart did not clear the pacing state");

   // A dropped frame leaves a nonzero drop count, a rendered one a zero count
   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.cmd == CMD_FINALIZE))
      |=> ((drops_ff != '0) == !rsp_ff.render) && (rsp_ff.drop_count == drops_ff))
      else $error("drop count disagrees with the render decision");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the A/V frame pacing block: directed cases, paced streams, noise.
`timescale 1ns / 1ps

module tb;
   import afps_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam longint T_MAX = longint'(TIME_MAX);
   localparam longint T_MIN = longint'(TIME_MIN);

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   afps_stream_if req_if ();
   afps_result_if rsp_if ();

   av_frame_pacing_sync_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Pacing state mirror and register copies
   longint pace_timer, pace_last_pts;
   longint hold_delay, hold_dur, hold_diff, hold_sleep;
   bit pace_running;
   int pace_drops;
   longint cfg_thr_min, cfg_thr_max, cfg_max_offset, cfg_min_sleep, cfg_max_sleep;
   longint cfg_resync_lag, cfg_drop_limit;

   rsp_type pending_pacing_results[$];
   int error_count = 0;
   int cycle_count = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int rsp_hold = 0;

   // Clamp to the signed time range
   function automatic longint sat_time(longint v);
      if (v > T_MAX) begin
         return T_MAX;
      end
      if (v < T_MIN) begin
         return T_MIN;
      end
      return v;
   endfunction

   // Low limit tested first, so it wins when the limits cross and the value is below it
   function automatic longint bound(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic time_type as_time(longint v);
      longint s;
      s = sat_time(v);
      return s[TIME_BITS-1:0];
   endfunction

   function automatic time_type rand_time();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 15))
         0: begin
            return TIME_MAX;
         end
         1: begin
            return TIME_MIN;
         end
         2: begin
            return '0;
         end
         3: begin
            return '1;
         end
         default: begin
            return raw[TIME_BITS-1:0];
         end
      endcase
   endfunction

   // Idle length: mostly none or short, a few long, with calm stretches of none
   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 110) begin
         return 0;
      end
      if (r < 170) begin
         return $urandom_range(1, 3);
      end
      if (r < 194) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_pacing_state();
      pace_timer = 0;
      pace_last_pts = -1;
      pace_running = 1'b0;
      pace_drops = 0;
      hold_delay = 0;
      hold_dur = 0;
      hold_diff = 0;
      hold_sleep = 0;
   endfunction

   // Advance the pacing state by one command; returns 1 when a result is due
   function automatic bit predict_pacing_result(input req_type it, output rsp_type res);
      longint pts, audio, wall, dur, diff, delay, thr, off, remaining;
      bit has_audio, started, draw_frame;
      pts = longint'($signed(it.frame_pts));
      audio = longint'($signed(it.audio_clock));
      wall = longint'($signed(it.wall_now));
      has_audio = (audio >= 0);
      started = 1'b0;
      draw_frame = 1'b0;
      res = '0;
      if (it.cmd == CMD_RESTART) begin
         clear_pacing_state();
         return 1'b0;
      end
      if (it.cmd == CMD_SPARE) begin
         return 1'b0;
      end
      if (it.cmd == CMD_PREPARE) begin
         // duration from a forward pts step, else the nominal one
         if (pace_last_pts >= 0 && pts > pace_last_pts) begin
            dur = bound(sat_time(pts - pace_last_pts), DUR_MIN, DUR_MAX);
         end else begin
            dur = longint'(it.nominal_duration);
         end
         pace_last_pts = pts;
         diff = has_audio ? sat_time(pts - audio) : 0;
         // first frame of a timeline starts the timer
         if (!pace_running) begin
            if (has_audio) begin
               off = bound(sat_time(audio - pts), -cfg_max_offset, cfg_max_offset);
               pace_timer = sat_time(wall - off);
            end else begin
               pace_timer = wall;
            end
            pace_running = 1'b1;
            started = 1'b1;
         end
         // shorten on lag, stretch or double on lead
         delay = dur;
         if (has_audio) begin
            thr = bound(dur, cfg_thr_min, cfg_thr_max);
            if (diff <= -thr) begin
               delay = sat_time(delay + diff);
               if (delay < 0) begin
                  delay = 0;
               end
            end else if (diff >= thr) begin
               delay = (delay > DUP_THRESHOLD) ? sat_time(delay + diff) : 2 * delay;
            end
         end
         remaining = sat_time(sat_time(pace_timer + delay) - wall);
         if (remaining <= cfg_min_sleep) begin
            hold_sleep = 0;
         end else begin
            hold_sleep = (remaining > cfg_max_sleep) ? cfg_max_sleep : remaining;
         end
         hold_delay = delay;
         hold_dur = dur;
         hold_diff = diff;
      end else begin
         // finalize: advance, resync on heavy lag, maybe drop
         pace_timer = sat_time(pace_timer + hold_delay);
         if (sat_time(wall - pace_timer) > cfg_resync_lag) begin
            pace_timer = wall;
         end
         draw_frame = 1'b1;
         if (has_audio && wall > sat_time(pace_timer + hold_dur) && pace_drops < cfg_drop_limit) begin
            draw_frame = 1'b0;
            pace_drops++;
         end
         if (draw_frame) begin
            pace_drops = 0;
         end
      end
      res.is_final = (it.cmd == CMD_FINALIZE);
      res.frame_duration = hold_dur[DUR_BITS-1:0];
      res.av_diff = hold_diff[TIME_BITS-1:0];
      res.delay = hold_delay[DELAY_BITS-1:0];
      res.sleep_time = hold_sleep[SLEEP_BITS-1:0];
      res.timeline_reset = started;
      res.frame_timer = pace_timer[TIME_BITS-1:0];
      res.drop_count = pace_drops[DROP_BITS-1:0];
      res.render = draw_frame;
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic [TIME_BITS-1:0] want,
                                       logic [TIME_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Result checker: each accepted transaction against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_pacing_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual frame_timer %0h",
                     $time, rsp_if.frame_timer);
            error_count++;
         end else begin
            want = pending_pacing_results.pop_front();
            check_field("is_final", want.is_final, rsp_if.is_final);
            check_field("frame_duration", want.frame_duration, rsp_if.frame_duration);
            check_field("av_diff", want.av_diff, rsp_if.av_diff);
            check_field("delay", want.delay, rsp_if.delay);
            check_field("sleep_time", want.sleep_time, rsp_if.sleep_time);
            check_field("timeline_reset", want.timeline_reset, rsp_if.timeline_reset);
            check_field("frame_timer", want.frame_timer, rsp_if.frame_timer);
            check_field("drop_count", want.drop_count, rsp_if.drop_count);
            check_field("render", want.render, rsp_if.render);
         end
      end
   end

   // Result back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold = pick_idle(rsp_calm);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Send one command transaction after a random gap; predict on acceptance
   task automatic send_pacing_cmd(input req_type it);
      int gap;
      rsp_type want;
      gap = pick_idle(req_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.cmd <= it.cmd;
      req_if.frame_pts <= it.frame_pts;
      req_if.nominal_duration <= it.nominal_duration;
      req_if.audio_clock <= it.audio_clock;
      req_if.wall_now <= it.wall_now;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (predict_pacing_result(it, want)) begin
         pending_pacing_results.push_back(want);
      end
   endtask

   task automatic send_fields(input logic [1:0] cmd, input longint pts, input longint nom,
                              input longint audio, input longint wall);
      req_type it;
      it.cmd = cmd;
      it.frame_pts = as_time(pts);
      it.nominal_duration = nom[DUR_BITS-1:0];
      it.audio_clock = as_time(audio);
      it.wall_now = as_time(wall);
      send_pacing_cmd(it);
   endtask

   // Stop sending and let every pending result (and any restart) drain
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_pacing_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input longint value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
   endtask

   // Block must be idle here
   task automatic load_config(input longint thr_lo, input longint thr_hi, input longint max_off,
                              input longint sleep_lo, input longint sleep_hi,
                              input longint lag, input longint drops_allowed);
      write_csr(CSR_SYNC_THR_MIN, thr_lo);
      write_csr(CSR_SYNC_THR_MAX, thr_hi);
      write_csr(CSR_MAX_AV_OFFSET, max_off);
      write_csr(CSR_MIN_SLEEP, sleep_lo);
      write_csr(CSR_MAX_SLEEP, sleep_hi);
      write_csr(CSR_RESYNC_LAG, lag);
      write_csr(CSR_DROP_LIMIT, drops_allowed);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_thr_min = thr_lo[THR_BITS-1:0];
      cfg_thr_max = thr_hi[THR_BITS-1:0];
      cfg_max_offset = max_off[OFFSET_BITS-1:0];
      cfg_min_sleep = sleep_lo[SLEEP_BITS-1:0];
      cfg_max_sleep = sleep_hi[SLEEP_BITS-1:0];
      cfg_resync_lag = lag[OFFSET_BITS-1:0];
      cfg_drop_limit = drops_allowed[DROP_BITS-1:0];
   endtask

   task automatic load_default_config();
      load_config(SYNC_THR_MIN_RST, SYNC_THR_MAX_RST, MAX_AV_OFFSET_RST, MIN_SLEEP_RST,
                  MAX_SLEEP_RST, RESYNC_LAG_RST, DROP_LIMIT_RST);
   endtask

   // Well-formed prepare/finalize pairs over a moving timeline, with some broken sequences
   task automatic run_paced_stream(input int n_frames);
      longint pts_now, wall_t, fin_wall, step, av_off, audio, nom;
      int r;
      pts_now = ($urandom_range(0, 19) == 0) ? T_MAX - longint'($urandom_range(0, 20000000))
                                             : longint'($urandom_range(0, 100000000));
      wall_t = ($urandom_range(0, 19) == 0) ? T_MAX - longint'($urandom_range(0, 20000000))
                                            : longint'($urandom_range(0, 1000000000));
      for (int f = 0; f < n_frames; f++) begin
         // pts step: common frame rates, odd steps, some backward
         r = $urandom_range(0, 99);
         if (r < 40) begin
            step = 33333;
         end else if (r < 60) begin
            step = 16667;
         end else if (r < 75) begin
            step = 40000;
         end else if (r < 92) begin
            step = $urandom_range(0, 1500000);
         end else begin
            step = -longint'($urandom_range(0, 100000));
         end
         pts_now = sat_time(pts_now + step);
         // audio offset from small drift to wild
         r = $urandom_range(0, 99);
         if (r < 45) begin
            av_off = longint'($urandom_range(0, 60000)) - 30000;
         end else if (r < 75) begin
            av_off = longint'($urandom_range(0, 400000)) - 200000;
         end else if (r < 92) begin
            av_off = longint'($urandom_range(0, 3000000)) - 1500000;
         end else begin
            av_off = longint'($urandom()) * 4096 - (longint'(1) << 43);
         end
         if ($urandom_range(0, 9) == 0) begin
            audio = -1 - longint'($urandom_range(0, 1000000));
         end else begin
            audio = sat_time(pts_now - av_off);
         end
         // wall clock mostly follows, sometimes jumps ahead
         if ($urandom_range(0, 9) != 0) begin
            wall_t = sat_time(wall_t + (step > 0 ? step : 16667)
                              + longint'($urandom_range(0, 70000)) - 20000);
         end else begin
            wall_t = sat_time(wall_t + longint'($urandom_range(100000, 3000000)));
         end
         fin_wall = sat_time(wall_t + longint'($urandom_range(0, 80000)));
         nom = ($urandom_range(0, 3) != 0) ? 33333 : longint'($urandom());
         r = $urandom_range(0, 99);
         if (r < 85) begin
            send_fields(CMD_PREPARE, pts_now, nom, audio, wall_t);
            send_fields(CMD_FINALIZE, pts_now, nom, audio, fin_wall);
         end else if (r < 91) begin
            send_fields(CMD_PREPARE, pts_now, nom, audio, wall_t);
         end else if (r < 96) begin
            send_fields(CMD_FINALIZE, pts_now, nom, audio, fin_wall);
         end else if (r < 99) begin
            send_fields(CMD_RESTART, pts_now, nom, audio, wall_t);
         end else begin
            send_fields(CMD_SPARE, pts_now, nom, audio, wall_t);
         end
         // sender holds off until all results are back
         if ($urandom_range(0, 49) == 0) begin
            wait_idle();
         end
      end
   endtask

   // Arbitrary field values and command codes
   task automatic run_random_noise(input int n_items);
      req_type it;
      for (int i = 0; i < n_items; i++) begin
         it.cmd = 2'($urandom_range(0, 3));
         it.frame_pts = rand_time();
         it.nominal_duration = DUR_BITS'($urandom());
         it.audio_clock = rand_time();
         it.wall_now = rand_time();
         send_pacing_cmd(it);
      end
   endtask

   task automatic test_directed_cases();
      longint p;
      load_default_config();
      // finalize with nothing prepared: zero held values
      send_fields(CMD_FINALIZE, 0, 0, -1, 0);
      // first prepare without audio: nominal duration, timer from wall
      send_fields(CMD_PREPARE, 0, 0, -1, 5000);
      // in sync, sleep between the limits
      send_fields(CMD_PREPARE, 33333, 40000, 0, 10000);
      send_fields(CMD_FINALIZE, 0, 0, 0, 20000);
      // long step: duration clamped high, lead stretches the delay, sleep capped
      p = 33333 + 2000000;
      send_fields(CMD_PREPARE, p, 0, 0, 30000);
      // tiny step: duration clamped low, lead doubles the delay
      p += 500;
      send_fields(CMD_PREPARE, p, 0, p - 60000, 40000);
      // lag beyond the duration: delay floors at zero
      p += 40000;
      send_fields(CMD_PREPARE, p, 0, p + 45000, 50000);
      // lag shorter than a long duration: delay shortened
      p += 500000;
      send_fields(CMD_PREPARE, p, 0, p + 200000, 60000);
      // pts going backwards: full-width nominal duration
      send_fields(CMD_PREPARE, 10, 16777215, -1, 70000);
      // one drop, render at the drop limit, then a resync
      send_fields(CMD_RESTART, 0, 0, 0, 0);
      send_fields(CMD_PREPARE, 0, 10000, 0, 0);
      send_fields(CMD_FINALIZE, 0, 0, 0, 80000);
      send_fields(CMD_FINALIZE, 0, 0, 0, 90000);
      send_fields(CMD_FINALIZE, 0, 0, 0, 500000);
      // start offset clamped on both sides
      send_fields(CMD_RESTART, 0, 0, 0, 0);
      send_fields(CMD_PREPARE, 0, 20000, 2000000, 1000000);
      send_fields(CMD_RESTART, 0, 0, 0, 0);
      send_fields(CMD_PREPARE, 3000000, 20000, 0, 1000000);
      // unused code is ignored
      send_fields(CMD_SPARE, 1, 1, 1, 1);
      // saturation at both ends of the time range
      send_fields(CMD_RESTART, 0, 0, 0, 0);
      send_fields(CMD_PREPARE, T_MAX, 16777215, 0, T_MIN);
      send_fields(CMD_FINALIZE, 0, 0, 0, T_MAX);
      send_fields(CMD_PREPARE, T_MIN, 0, T_MAX, T_MAX);
      send_fields(CMD_FINALIZE, 0, 0, -1, T_MIN);
   endtask

   task automatic test_default_pacing();
      wait_idle();
      load_default_config();
      run_paced_stream(60);
   endtask

   task automatic test_zero_limits();
      wait_idle();
      load_config(0, 0, 0, 0, 0, 0, 0);
      run_paced_stream(30);
      run_random_noise(15);
   endtask

   task automatic test_top_limits();
      wait_idle();
      load_config(1000000, 1000000, 10000000, 1000000, 1000000, 10000000, 255);
      run_paced_stream(30);
      run_random_noise(15);
   endtask

   task automatic test_inverted_thresholds();
      wait_idle();
      load_config(100000, 20000, MAX_AV_OFFSET_RST, MIN_SLEEP_RST, MAX_SLEEP_RST,
                  RESYNC_LAG_RST, DROP_LIMIT_RST);
      run_paced_stream(30);
   endtask

   task automatic test_random_settings();
      for (int k = 0; k < 3; k++) begin
         wait_idle();
         load_config($urandom_range(0, 150000), $urandom_range(0, 400000),
                     $urandom_range(0, 10000000), $urandom_range(0, 50000),
                     $urandom_range(0, 1000000), $urandom_range(0, 10000000),
                     (k == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4));
         run_paced_stream(25);
         run_random_noise(12);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_PREPARE;
      req_if.frame_pts = '0;
      req_if.nominal_duration = '0;
      req_if.audio_clock = '0;
      req_if.wall_now = '0;
      rsp_if.ready = 1'b0;
      clear_pacing_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_default_pacing();
      test_zero_limits();
      test_top_limits();
      test_inverted_thresholds();
      test_random_settings();

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
